FILE: hw/rtl/cbm_pkg.sv
package cbm_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_TICK  = 2'd1,
      CMD_CPU   = 2'd2,
      CMD_PPU   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type     cmd;
      logic [15:0] address;
      logic [7:0]  data;
      logic        render_active;
   } req_type;

   typedef struct packed {
      logic [18:0] rom_offset;
      logic        irq_fire;
      logic        mirror_horizontal;
   } rsp_type;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 9;

   localparam logic [CSR_INDEX_W-1:0] CSR_OLD_BOARD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRG_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHR_COUNT = 2'd2;

   localparam int PRG_MASK_W = 6;
   localparam int CHR_MASK_W = 8;
   localparam int CHR_BANKS  = 6;
   localparam int CHR_IDX_W  = $clog2(CHR_BANKS);

   localparam logic [PRG_MASK_W-1:0] PRG_MASK_RESET = 6'd15;
   localparam logic [CHR_MASK_W-1:0] CHR_MASK_RESET = 8'd255;

   localparam logic [15:0] ADDR_PRG_A  = 16'h8000;
   localparam logic [15:0] ADDR_PRG_B  = 16'h8001;
   localparam logic [15:0] ADDR_CHR_0  = 16'h8002;
   localparam logic [15:0] ADDR_CHR_1  = 16'h8003;
   localparam logic [15:0] ADDR_CHR_2  = 16'hA000;
   localparam logic [15:0] ADDR_CHR_3  = 16'hA001;
   localparam logic [15:0] ADDR_CHR_4  = 16'hA002;
   localparam logic [15:0] ADDR_CHR_5  = 16'hA003;
   localparam logic [15:0] ADDR_IRQ_LD = 16'hC000;
   localparam logic [15:0] ADDR_IRQ_RL = 16'hC001;
   localparam logic [15:0] ADDR_IRQ_ON = 16'hC002;
   localparam logic [15:0] ADDR_IRQ_OF = 16'hC003;
   localparam logic [15:0] ADDR_MIRROR = 16'hE000;

   localparam logic [7:0] OLD_PRG_MASK = 8'h1F;
   localparam int         MIRROR_BIT   = 6;

   typedef struct packed {
      logic [PRG_MASK_W-1:0]        prg_mask;
      logic [CHR_MASK_W-1:0]        chr_mask;
      logic [7:0]                   prg_bank_a;
      logic [7:0]                   prg_bank_b;
      logic [CHR_BANKS-1:0][7:0]    chr_banks;
   } bank_type;

   typedef struct packed {
      logic irq_fire;
      logic mirror_next;
      logic irq_armed;
   } upd_type;

   // mask of the largest power of two not above n, zero acts as one
   function automatic logic [8:0] pow2_mask(input logic [8:0] n);
      logic [8:0] s;
      s = n;
      s = s | (s >> 1);
      s = s | (s >> 2);
      s = s | (s >> 4);
      s = s | (s >> 8);
      return s >> 1;
   endfunction

endpackage

FILE: hw/rtl/cbm_regs.sv
module cbm_regs (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  cbm_pkg::req_type                     req,
   input  logic                                 csr_we,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]       csr_data,
   output cbm_pkg::bank_type                    bank,
   output cbm_pkg::upd_type                     upd
);

   logic                                 old_board_ff, old_board_in;
   logic [cbm_pkg::PRG_MASK_W-1:0]       prg_mask_ff, prg_mask_in;
   logic [cbm_pkg::CHR_MASK_W-1:0]       chr_mask_ff, chr_mask_in;
   logic [7:0]                           prg_a_ff, prg_a_in;
   logic [7:0]                           prg_b_ff, prg_b_in;
   logic [cbm_pkg::CHR_BANKS-1:0][7:0]   chr_ff, chr_in;
   logic [7:0]                           reload_ff, reload_in;
   logic [7:0]                           count_ff, count_in;
   logic                                 armed_ff, armed_in;
   logic                                 mirror_ff, mirror_in;
   logic                                 fire;
   logic [7:0]                           prg_data;
   logic [8:0]                           prg_full;
   logic [8:0]                           chr_full;

   always_comb begin
      old_board_in = old_board_ff;
      prg_mask_in  = prg_mask_ff;
      chr_mask_in  = chr_mask_ff;
      prg_full     = cbm_pkg::pow2_mask({2'b00, csr_data[6:0]});
      chr_full     = cbm_pkg::pow2_mask(csr_data);
      if (csr_we) begin
         case (csr_index)
            cbm_pkg::CSR_OLD_BOARD: old_board_in = csr_data[0];
            cbm_pkg::CSR_PRG_COUNT: prg_mask_in  = prg_full[cbm_pkg::PRG_MASK_W-1:0];
            cbm_pkg::CSR_CHR_COUNT: chr_mask_in  = chr_full[cbm_pkg::CHR_MASK_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      prg_a_in  = prg_a_ff;
      prg_b_in  = prg_b_ff;
      chr_in    = chr_ff;
      reload_in = reload_ff;
      count_in  = count_ff;
      armed_in  = armed_ff;
      mirror_in = mirror_ff;
      fire      = 1'b0;
      prg_data  = old_board_ff ? (req.data & cbm_pkg::OLD_PRG_MASK) : req.data;
      if (go) begin
         case (req.cmd)
            cbm_pkg::CMD_WRITE: begin
               case (req.address)
                  cbm_pkg::ADDR_PRG_A: begin
                     prg_a_in = prg_data;
                     if (old_board_ff) begin
                        mirror_in = req.data[cbm_pkg::MIRROR_BIT];
                     end
                  end
                  cbm_pkg::ADDR_PRG_B:  prg_b_in  = prg_data;
                  cbm_pkg::ADDR_CHR_0:  chr_in[0] = req.data;
                  cbm_pkg::ADDR_CHR_1:  chr_in[1] = req.data;
                  cbm_pkg::ADDR_CHR_2:  chr_in[2] = req.data;
                  cbm_pkg::ADDR_CHR_3:  chr_in[3] = req.data;
                  cbm_pkg::ADDR_CHR_4:  chr_in[4] = req.data;
                  cbm_pkg::ADDR_CHR_5:  chr_in[5] = req.data;
                  cbm_pkg::ADDR_IRQ_LD: begin
                     reload_in = req.data;
                     count_in  = req.data;
                  end
                  cbm_pkg::ADDR_IRQ_RL: count_in  = reload_ff;
                  cbm_pkg::ADDR_IRQ_ON: armed_in  = 1'b1;
                  cbm_pkg::ADDR_IRQ_OF: armed_in  = 1'b0;
                  cbm_pkg::ADDR_MIRROR: mirror_in = req.data[cbm_pkg::MIRROR_BIT];
                  default: ;
               endcase
            end
            cbm_pkg::CMD_TICK: begin
               if (req.render_active && armed_ff) begin
                  count_in = count_ff + 8'd1;
                  if (count_ff == 8'hFF) begin
                     armed_in = 1'b0;
                     fire     = 1'b1;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         old_board_ff <= 1'b0;
         prg_mask_ff  <= cbm_pkg::PRG_MASK_RESET;
         chr_mask_ff  <= cbm_pkg::CHR_MASK_RESET;
         prg_a_ff     <= 8'd0;
         prg_b_ff     <= 8'd1;
         chr_ff       <= {8'd7, 8'd6, 8'd5, 8'd4, 8'd2, 8'd0};
         reload_ff    <= 8'd0;
         count_ff     <= 8'd0;
         armed_ff     <= 1'b0;
         mirror_ff    <= 1'b0;
      end else begin
         old_board_ff <= old_board_in;
         prg_mask_ff  <= prg_mask_in;
         chr_mask_ff  <= chr_mask_in;
         prg_a_ff     <= prg_a_in;
         prg_b_ff     <= prg_b_in;
         chr_ff       <= chr_in;
         reload_ff    <= reload_in;
         count_ff     <= count_in;
         armed_ff     <= armed_in;
         mirror_ff    <= mirror_in;
      end
   end

   assign bank.prg_mask   = prg_mask_ff;
   assign bank.chr_mask   = chr_mask_ff;
   assign bank.prg_bank_a = prg_a_ff;
   assign bank.prg_bank_b = prg_b_ff;
   assign bank.chr_banks  = chr_ff;

   assign upd.irq_fire    = fire;
   assign upd.mirror_next = mirror_in;
   assign upd.irq_armed   = armed_ff;

endmodule

FILE: hw/rtl/cbm_xlate.sv
module cbm_xlate (
   input  cbm_pkg::req_type   req,
   input  cbm_pkg::bank_type  bank,
   output logic [18:0]        rom_offset
);

   logic [cbm_pkg::PRG_MASK_W-1:0] prg_bank;
   logic [2:0]                     slot;
   logic [cbm_pkg::CHR_IDX_W-1:0]  chr_idx;
   logic [8:0]                     unit;
   logic [8:0]                     unit_masked;

   always_comb begin
      case (req.address[14:13])
         2'd0:    prg_bank = bank.prg_bank_a[cbm_pkg::PRG_MASK_W-1:0];
         2'd1:    prg_bank = bank.prg_bank_b[cbm_pkg::PRG_MASK_W-1:0];
         2'd2:    prg_bank = bank.prg_mask - 6'd1;
         default: prg_bank = bank.prg_mask;
      endcase
      prg_bank = prg_bank & bank.prg_mask;

      slot = req.address[12:10];
      if (!slot[2]) begin
         chr_idx = {1'b0, slot[2:1]};
         unit    = {bank.chr_banks[chr_idx], slot[0]};
      end else begin
         chr_idx = slot - 3'd2;
         unit    = {1'b0, bank.chr_banks[chr_idx]};
      end
      unit_masked = unit & {1'b0, bank.chr_mask};

      case (req.cmd)
         cbm_pkg::CMD_CPU: begin
            rom_offset = req.address[15] ? {prg_bank, req.address[12:0]} : 19'd0;
         end
         cbm_pkg::CMD_PPU: begin
            rom_offset = (req.address[15:13] == 3'd0)
                       ? {1'b0, unit_masked[7:0], req.address[9:0]} : 19'd0;
         end
         default: rom_offset = 19'd0;
      endcase
   end

endmodule

FILE: hw/rtl/cartridge_bank_mapper_irq.sv
// Bank mapper with scanline interrupt. Each request (register write, scanline tick,
// CPU or PPU translate) passes an input register, the single register stage between
// input and response, then bank lookup and state update into the response register;
// one transfer per clock sustained while rsp_ready stays high. The user must write bank
// counts on the csr port only while no request is in flight; the block does not
// enforce this. csr_ready is always high; a csr write takes effect on the next cycle.
module cartridge_bank_mapper_irq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cbm_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output cbm_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbm_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [cbm_pkg::CSR_DATA_W-1:0]      csr_data
);

   logic              s1_valid_ff, s1_valid_in;
   cbm_pkg::req_type  s1_req_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   cbm_pkg::rsp_type  rsp_ff;
   logic              s1_go;
   cbm_pkg::bank_type bank;
   cbm_pkg::upd_type  upd;
   logic [18:0]       offset;

   assign s1_go     = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign csr_ready = 1'b1;

   assign s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ready);

   cbm_regs u_regs (
      .clock     (clock),
      .reset     (reset),
      .go        (s1_go),
      .req       (s1_req_ff),
      .csr_we    (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .bank      (bank),
      .upd       (upd)
   );

   cbm_xlate u_xlate (
      .req        (s1_req_ff),
      .bank       (bank),
      .rom_offset (offset)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_payload;
      end
      if (s1_go) begin
         rsp_ff.rom_offset        <= offset;
         rsp_ff.irq_fire          <= upd.irq_fire;
         rsp_ff.mirror_horizontal <= upd.mirror_next;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_rst_empty: assert property (@(posedge clock) reset |=> !rsp_valid_ff && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_fire_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.irq_fire |-> rsp_ff.rom_offset == 19'd0)
      else $error("irq response carries an offset");

   a_fire_disarm: assert property (@(posedge clock) disable iff (reset)
      s1_go && upd.irq_fire |=> !upd.irq_armed)
      else $error("irq still armed after firing");

   a_fire_armed: assert property (@(posedge clock) disable iff (reset)
      upd.irq_fire |-> upd.irq_armed && s1_req_ff.cmd == cbm_pkg::CMD_TICK)
      else $error("irq fired while disarmed or not on a tick");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_go |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("stalled request lost");

endmodule

FILE: bench/tb_cartridge_bank_mapper_irq.sv
module tb_cartridge_bank_mapper_irq;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cbm_pkg::CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;
   localparam int NUM_REGS = 13;
   localparam logic [15:0] REG_ADDRS [NUM_REGS] = '{
      cbm_pkg::ADDR_PRG_A, cbm_pkg::ADDR_PRG_B, cbm_pkg::ADDR_CHR_0, cbm_pkg::ADDR_CHR_1,
      cbm_pkg::ADDR_CHR_2, cbm_pkg::ADDR_CHR_3, cbm_pkg::ADDR_CHR_4, cbm_pkg::ADDR_CHR_5,
      cbm_pkg::ADDR_IRQ_LD, cbm_pkg::ADDR_IRQ_RL, cbm_pkg::ADDR_IRQ_ON, cbm_pkg::ADDR_IRQ_OF,
      cbm_pkg::ADDR_MIRROR
   };

   typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC, READY_SPARSE} ready_mode_type;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_ready;
   cbm_pkg::req_type                req_payload;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   cbm_pkg::rsp_type                rsp_payload;
   logic                            csr_valid;
   logic                            csr_ready;
   logic [cbm_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [cbm_pkg::CSR_DATA_W-1:0]  csr_data;

   cartridge_bank_mapper_irq dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always #6 clock = ~clock;

   // mapper state mirrored in the bench
   logic       m_old_board;
   logic [6:0] m_prg_count;
   logic [8:0] m_chr_count;
   logic [7:0] m_prg_a;
   logic [7:0] m_prg_b;
   logic [7:0] m_chr [cbm_pkg::CHR_BANKS];
   logic [7:0] m_irq_reload;
   logic [7:0] m_irq_count;
   logic       m_irq_armed;
   logic       m_mirror;

   cbm_pkg::rsp_type rsp_due [$];
   int               mismatches = 0;
   int               items_sent = 0;
   int               burst_left = 0;

   function automatic void mapper_reset();
      m_old_board  = 1'b0;
      m_prg_count  = 7'd16;
      m_chr_count  = 9'd256;
      m_prg_a      = 8'd0;
      m_prg_b      = 8'd1;
      m_chr        = '{8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7};
      m_irq_reload = 8'd0;
      m_irq_count  = 8'd0;
      m_irq_armed  = 1'b0;
      m_mirror     = 1'b0;
   endfunction

   // largest power of two not above n, zero counts as one
   function automatic int unsigned floor_pow2(input logic [8:0] n);
      for (int i = 8; i >= 0; i--) begin
         if (n[i]) return 32'd1 << i;
      end
      return 32'd1;
   endfunction

   function automatic void bank_write(input logic [15:0] a, input logic [7:0] d);
      case (a)
         cbm_pkg::ADDR_PRG_A: begin
            if (m_old_board) begin
               m_mirror = d[cbm_pkg::MIRROR_BIT];
               m_prg_a  = d & cbm_pkg::OLD_PRG_MASK;
            end else begin
               m_prg_a = d;
            end
         end
         cbm_pkg::ADDR_PRG_B:  m_prg_b = m_old_board ? (d & cbm_pkg::OLD_PRG_MASK) : d;
         cbm_pkg::ADDR_CHR_0:  m_chr[0] = d;
         cbm_pkg::ADDR_CHR_1:  m_chr[1] = d;
         cbm_pkg::ADDR_CHR_2:  m_chr[2] = d;
         cbm_pkg::ADDR_CHR_3:  m_chr[3] = d;
         cbm_pkg::ADDR_CHR_4:  m_chr[4] = d;
         cbm_pkg::ADDR_CHR_5:  m_chr[5] = d;
         cbm_pkg::ADDR_IRQ_LD: begin
            m_irq_reload = d;
            m_irq_count  = d;
         end
         cbm_pkg::ADDR_IRQ_RL: m_irq_count = m_irq_reload;
         cbm_pkg::ADDR_IRQ_ON: m_irq_armed = 1'b1;
         cbm_pkg::ADDR_IRQ_OF: m_irq_armed = 1'b0;
         cbm_pkg::ADDR_MIRROR: m_mirror = d[cbm_pkg::MIRROR_BIT];
         default: ;
      endcase
   endfunction

   function automatic cbm_pkg::rsp_type mapper_response(input cbm_pkg::req_type r);
      cbm_pkg::rsp_type o;
      int unsigned      span;
      int unsigned      bank;
      o = '0;
      case (r.cmd)
         cbm_pkg::CMD_WRITE: bank_write(r.address, r.data);
         cbm_pkg::CMD_TICK: begin
            if (r.render_active && m_irq_armed) begin
               m_irq_count = m_irq_count + 8'd1;
               if (m_irq_count == 8'd0) begin
                  m_irq_armed = 1'b0;
                  o.irq_fire  = 1'b1;
               end
            end
         end
         cbm_pkg::CMD_CPU: begin
            if (r.address >= 16'h8000) begin
               span = floor_pow2({2'b00, m_prg_count});
               case (r.address[14:13])
                  2'd0:    bank = m_prg_a;
                  2'd1:    bank = m_prg_b;
                  2'd2:    bank = span - 2;
                  default: bank = span - 1;
               endcase
               bank = bank & (span - 1);
               o.rom_offset = 19'((bank << 13) | r.address[12:0]);
            end
         end
         default: begin
            if (r.address < 16'h2000) begin
               span = floor_pow2(m_chr_count);
               if (!r.address[12]) bank = {m_chr[r.address[11]], r.address[10]};
               else bank = m_chr[2 + r.address[11:10]];
               bank = bank & (span - 1);
               o.rom_offset = 19'((bank << 10) | r.address[9:0]);
            end
         end
      endcase
      o.mirror_horizontal = m_mirror;
      return o;
   endfunction

   function automatic cbm_pkg::req_type make_req(input cbm_pkg::cmd_type c,
                                                 input logic [15:0] a,
                                                 input logic [7:0] d, input logic ra);
      cbm_pkg::req_type r;
      r.cmd           = c;
      r.address       = a;
      r.data          = d;
      r.render_active = ra;
      return r;
   endfunction

   task automatic send_item(input cbm_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (!req_ready);
      rsp_due.push_back(mapper_response(r));
      items_sent++;
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      burst_left = 0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic [cbm_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [cbm_pkg::CSR_DATA_W-1:0] val);
      drain_pipeline();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         cbm_pkg::CSR_OLD_BOARD: m_old_board = val[0];
         cbm_pkg::CSR_PRG_COUNT: m_prg_count = val[6:0];
         cbm_pkg::CSR_CHR_COUNT: m_chr_count = val[8:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_state();
      send_item(make_req(cbm_pkg::CMD_CPU, 16'h0000, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_CPU, 16'h8000, 8'hFF, 1'b1));
      send_item(make_req(cbm_pkg::CMD_CPU, 16'hFFFF, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_PPU, 16'h1FFF, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_PPU, 16'hFFFF, 8'hFF, 1'b1));
   endtask

   task automatic test_bank_registers();
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_PRG_A, 8'hFF, 1'b0));
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_CHR_1, 8'h00, 1'b1));
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_CHR_5, 8'h80, 1'b0));
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_MIRROR, 8'h40, 1'b0));
      // unmapped write address leaves state alone
      send_item(make_req(cbm_pkg::CMD_WRITE, 16'hFFFF, 8'hFF, 1'b1));
      send_item(make_req(cbm_pkg::CMD_CPU, 16'h9FFF, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_PPU, 16'h0BFF, 8'h00, 1'b0));
   endtask

   task automatic test_scanline_irq();
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_LD, 8'hFE, 1'b0));
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_ON, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b1));
      send_item(make_req(cbm_pkg::CMD_TICK, 16'hFFFF, 8'hFF, 1'b1));
      send_item(make_req(cbm_pkg::CMD_TICK, 16'h0000, 8'h00, 1'b1));
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_RL, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_OF, 8'h00, 1'b0));
   endtask

   task automatic test_old_board();
      write_csr(cbm_pkg::CSR_OLD_BOARD, 9'd1);
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_PRG_A, 8'hFF, 1'b0));
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_PRG_B, 8'hE0, 1'b0));
      send_item(make_req(cbm_pkg::CMD_CPU, 16'h8000, 8'h00, 1'b0));
      write_csr(cbm_pkg::CSR_OLD_BOARD, 9'd0);
   endtask

   task automatic test_bank_counts();
      write_csr(cbm_pkg::CSR_PRG_COUNT, 9'd2);
      write_csr(cbm_pkg::CSR_CHR_COUNT, 9'd8);
      send_item(make_req(cbm_pkg::CMD_CPU, 16'hC000, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_PPU, 16'h1C00, 8'h00, 1'b0));
      // zero counts act as a single bank
      write_csr(cbm_pkg::CSR_PRG_COUNT, 9'd0);
      write_csr(cbm_pkg::CSR_CHR_COUNT, 9'd0);
      send_item(make_req(cbm_pkg::CMD_CPU, 16'hE000, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_PPU, 16'h0400, 8'h00, 1'b0));
      // counts that are not a power of two round down
      write_csr(cbm_pkg::CSR_PRG_COUNT, 9'd100);
      write_csr(cbm_pkg::CSR_CHR_COUNT, 9'd300);
      write_csr(CSR_UNUSED, 9'h1FF);
      send_item(make_req(cbm_pkg::CMD_CPU, 16'hFFFF, 8'h00, 1'b0));
      send_item(make_req(cbm_pkg::CMD_PPU, 16'h0C00, 8'h00, 1'b0));
   endtask

   task automatic irq_sequence();
      logic [7:0] ld;
      int         ticks;
      ld = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(236, 255));
      ticks = $urandom_range(1, 24);
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_LD, ld,
                         1'($urandom_range(0, 1))));
      if ($urandom_range(0, 3) == 0)
         send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_RL, 8'($urandom),
                            1'($urandom_range(0, 1))));
      send_item(make_req(cbm_pkg::CMD_WRITE, cbm_pkg::ADDR_IRQ_ON, 8'($urandom),
                         1'($urandom_range(0, 1))));
      repeat (ticks) begin
         send_item(make_req(cbm_pkg::CMD_TICK, 16'($urandom), 8'($urandom),
                            ($urandom_range(0, 7) != 0)));
      end
   endtask

   task automatic random_item();
      int         pick;
      logic [15:0] a;
      pick = $urandom_range(0, 99);
      a    = 16'($urandom);
      if (pick < 20) begin
         irq_sequence();
      end else if (pick < 40) begin
         send_item(make_req(cbm_pkg::CMD_WRITE, REG_ADDRS[$urandom_range(0, NUM_REGS - 1)],
                            8'($urandom), 1'($urandom_range(0, 1))));
      end else if (pick < 55) begin
         send_item(make_req(cbm_pkg::CMD_TICK, a, 8'($urandom), 1'($urandom_range(0, 1))));
      end else if (pick < 75) begin
         if ($urandom_range(0, 4) != 0) a[15] = 1'b1;
         send_item(make_req(cbm_pkg::CMD_CPU, a, 8'($urandom), 1'($urandom_range(0, 1))));
      end else if (pick < 95) begin
         if ($urandom_range(0, 4) != 0) a[15:13] = 3'b000;
         send_item(make_req(cbm_pkg::CMD_PPU, a, 8'($urandom), 1'($urandom_range(0, 1))));
      end else begin
         send_item(make_req(cbm_pkg::cmd_type'(2'($urandom_range(0, 3))), a, 8'($urandom),
                            1'($urandom_range(0, 1))));
      end
   endtask

   task automatic test_random_traffic(input int count);
      int target;
      int phase_end;
      int phase;
      phase  = 0;
      target = items_sent + count;
      while (items_sent < target) begin
         if (phase == 0) begin
            write_csr(cbm_pkg::CSR_OLD_BOARD, 9'd0);
            write_csr(cbm_pkg::CSR_PRG_COUNT, 9'd64);
            write_csr(cbm_pkg::CSR_CHR_COUNT, 9'd256);
         end else if (phase == 1) begin
            write_csr(cbm_pkg::CSR_OLD_BOARD, 9'd1);
            write_csr(cbm_pkg::CSR_PRG_COUNT, 9'd2);
            write_csr(cbm_pkg::CSR_CHR_COUNT, 9'd8);
         end else if (phase % 5 == 4) begin
            write_csr(cbm_pkg::CSR_OLD_BOARD, 9'($urandom_range(0, 1)));
            write_csr(cbm_pkg::CSR_PRG_COUNT, 9'($urandom_range(0, 127)));
            write_csr(cbm_pkg::CSR_CHR_COUNT, 9'($urandom_range(0, 511)));
         end else begin
            write_csr(cbm_pkg::CSR_OLD_BOARD, 9'($urandom_range(0, 1)));
            write_csr(cbm_pkg::CSR_PRG_COUNT, 9'(1 << $urandom_range(1, 6)));
            write_csr(cbm_pkg::CSR_CHR_COUNT, 9'(1 << $urandom_range(3, 8)));
         end
         phase_end = items_sent + 130;
         while (items_sent < phase_end && items_sent < target) random_item();
         phase++;
      end
   endtask

   // response side stalls on a pattern that changes every so often
   int             stall_cycle = 0;
   ready_mode_type stall_mode  = READY_ALWAYS;

   always @(posedge clock) begin
      stall_cycle++;
      if (stall_cycle % 150 == 0) stall_mode = ready_mode_type'($urandom_range(0, 3));
      case (stall_mode)
         READY_ALWAYS:   rsp_ready <= 1'b1;
         READY_RANDOM:   rsp_ready <= ($urandom_range(0, 3) != 0);
         READY_PERIODIC: rsp_ready <= ((stall_cycle % 7) < 3);
         default:        rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   always @(posedge clock) begin : rsp_check
      cbm_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (rsp_due.size() == 0) begin
            $error("response transfer with nothing outstanding");
            mismatches++;
         end else begin
            want = rsp_due.pop_front();
            if (rsp_payload.rom_offset !== want.rom_offset) begin
               $error("rom_offset expected %0h actual %0h", want.rom_offset,
                      rsp_payload.rom_offset);
               mismatches++;
            end
            if (rsp_payload.irq_fire !== want.irq_fire) begin
               $error("irq_fire expected %0b actual %0b", want.irq_fire, rsp_payload.irq_fire);
               mismatches++;
            end
            if (rsp_payload.mirror_horizontal !== want.mirror_horizontal) begin
               $error("mirror_horizontal expected %0b actual %0b", want.mirror_horizontal,
                      rsp_payload.mirror_horizontal);
               mismatches++;
            end
         end
      end
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int waited;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      mapper_reset();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_bank_registers();
      test_scanline_irq();
      test_old_board();
      test_bank_counts();
      test_random_traffic(1300);

      req_valid <= 1'b0;
      waited = 0;
      while (rsp_due.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (rsp_due.size() != 0) begin
         $error("%0d responses never arrived", rsp_due.size());
         mismatches++;
      end
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
